@@ rtl/core/gpad_pkg.sv @@
// shared types, register indexes and constants for the gamepad report axis decoder
package gpad_pkg;

  localparam int unsigned StickW = 16;
  localparam int unsigned TrigW  = 15;

  localparam logic [7:0] TRIG_CENTER    = 8'd128;
  localparam logic [7:0] MIN_REPORT_LEN = 8'd11;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_SIDE_THRESHOLD   = 2'd0,
    CFG_STABLE_NOISE     = 2'd1,
    CFG_RELEASE_MOVEMENT = 2'd2,
    CFG_ARM_DELAY_TICKS  = 2'd3
  } cfg_index_t;

  // input item kinds
  typedef enum logic {
    MODE_REPORT = 1'b0,
    MODE_TICK   = 1'b1
  } mode_t;

  // trigger side codes
  typedef enum logic [1:0] {
    SIDE_NONE  = 2'd0,
    SIDE_LEFT  = 2'd1,
    SIDE_RIGHT = 2'd2
  } side_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] report_length;
    logic [7:0] left_x_raw;
    logic [7:0] left_y_raw;
    logic [7:0] right_x_raw;
    logic [7:0] right_y_raw;
    logic [7:0] status_byte;
    logic [7:0] combined_trigger;
  } in_item_t;

  typedef struct packed {
    logic                     axes_valid;
    logic signed [StickW-1:0] left_x;
    logic signed [StickW-1:0] left_y;
    logic signed [StickW-1:0] right_x;
    logic signed [StickW-1:0] right_y;
    logic [TrigW-1:0]         left_trigger;
    logic [TrigW-1:0]         right_trigger;
    logic                     both_held_flag;
  } out_item_t;

  typedef struct packed {
    logic [6:0]  side_threshold;
    logic [7:0]  stable_noise;
    logic [7:0]  release_movement;
    logic [15:0] arm_delay_ticks;
  } cfg_t;

  typedef struct packed {
    logic        digital_active;
    side_t       first_side;
    logic        both_held;
    logic        release_armed;
    logic [7:0]  last_trigger_value;
    logic [15:0] stable_ticks;
  } trig_state_t;

  localparam cfg_t CFG_RESET = '{
    side_threshold:   7'd10,
    stable_noise:     8'd2,
    release_movement: 8'd12,
    arm_delay_ticks:  16'd80
  };

  localparam trig_state_t STATE_RESET = '{
    digital_active:     1'b0,
    first_side:         SIDE_NONE,
    both_held:          1'b0,
    release_armed:      1'b0,
    last_trigger_value: TRIG_CENTER,
    stable_ticks:       16'd0
  };

  // stick byte to signed axis: (raw - 128) * 256
  function automatic logic signed [StickW-1:0] stick_axis(input logic [7:0] raw);
    stick_axis = {~raw[7], raw[6:0], 8'h00};
  endfunction

endpackage

@@ rtl/core/gpad_update.sv @@
// decode of one item: trigger state update and result fields
module gpad_update (
  input  gpad_pkg::in_item_t    item,
  input  gpad_pkg::cfg_t        cfg,
  input  gpad_pkg::trig_state_t state,
  output gpad_pkg::trig_state_t state_nxt,
  output gpad_pkg::out_item_t   result
);
  import gpad_pkg::*;

  logic [7:0]  c;
  side_t       side;
  logic [7:0]  movement;
  logic [7:0]  left_mag;
  logic [6:0]  right_mag;
  logic [15:0] left_scaled;
  logic [14:0] right_scaled;
  trig_state_t st;

  assign c = item.combined_trigger;

  always_comb begin
    if (({1'b0, c} + {2'b0, cfg.side_threshold}) < {1'b0, TRIG_CENTER}) begin
      side = SIDE_LEFT;
    end else if ({1'b0, c} > ({1'b0, TRIG_CENTER} + {2'b0, cfg.side_threshold})) begin
      side = SIDE_RIGHT;
    end else begin
      side = SIDE_NONE;
    end
  end

  assign movement = (c > state.last_trigger_value) ? (c - state.last_trigger_value)
                                                    : (state.last_trigger_value - c);

  // left: (128-c)*32767/128 is exactly (128-c)*256 - 1
  assign left_mag    = TRIG_CENTER - c;
  assign left_scaled = {left_mag, 8'h00} - 16'd1;
  // right: (c-128)*32767/127 is (c-128)*258, plus one at full travel
  assign right_mag    = c[6:0];
  assign right_scaled = {right_mag, 8'h00} + {7'b0, right_mag, 1'b0}
                        + {14'b0, (right_mag == 7'd127)};

  always_comb begin
    st = state;
    if (item.mode == MODE_TICK) begin
      if (state.stable_ticks != 16'hffff) begin
        st.stable_ticks = state.stable_ticks + 16'd1;
      end
    end else if (item.report_length >= MIN_REPORT_LEN) begin
      if (!item.status_byte[7]) begin
        st = STATE_RESET;
      end else if (!state.digital_active) begin
        st.digital_active     = 1'b1;
        st.first_side         = side;
        st.last_trigger_value = c;
        st.stable_ticks       = 16'd0;
      end else if (!state.both_held) begin
        if (state.first_side == SIDE_NONE && side != SIDE_NONE) begin
          st.first_side = side;
        end else if (side != SIDE_NONE && state.first_side != SIDE_NONE &&
                     side != state.first_side) begin
          st.both_held     = 1'b1;
          st.release_armed = 1'b0;
          st.stable_ticks  = 16'd0;
        end
        st.last_trigger_value = c;
      end else begin
        if (!state.release_armed) begin
          if (movement <= cfg.stable_noise) begin
            if (state.stable_ticks >= cfg.arm_delay_ticks) begin
              st.release_armed = 1'b1;
            end
          end else begin
            st.stable_ticks = 16'd0;
          end
        end else if (movement >= cfg.release_movement) begin
          st.both_held     = 1'b0;
          st.first_side    = side;
          st.release_armed = 1'b0;
          st.stable_ticks  = 16'd0;
        end
        st.last_trigger_value = c;
      end
    end
  end

  assign state_nxt = st;

  always_comb begin
    result = '0;
    if (item.report_length >= MIN_REPORT_LEN) begin
      result.axes_valid = 1'b1;
      result.left_x     = stick_axis(item.left_x_raw);
      result.left_y     = stick_axis(item.left_y_raw);
      result.right_x    = stick_axis(item.right_x_raw);
      result.right_y    = stick_axis(item.right_y_raw);
      if (st.both_held) begin
        result.left_trigger   = '1;
        result.right_trigger  = '1;
        result.both_held_flag = 1'b1;
      end else begin
        if (c < TRIG_CENTER) begin
          result.left_trigger = left_scaled[TrigW-1:0];
        end
        if (c > TRIG_CENTER) begin
          result.right_trigger = right_scaled;
        end
      end
    end
  end

endmodule

@@ rtl/core/gamepad_report_axis_decoder_core.sv @@
// top level of the gamepad report axis decoder: item registers, config and trigger state
// Each input item is either a report or a one millisecond tick. A report gives one
// result item: four signed stick axes ((byte-128)*256), left and right trigger
// values taken from the shared trigger byte, and a flag that is set while both
// triggers are deemed held (then both triggers read full scale). A report shorter
// than 11 bytes gives an all-zero result and leaves the trigger state alone. A tick
// gives no result and only advances the saturating stability counter used to arm
// release. An item is taken every cycle while the result register is not stalled; a
// result can be taken once its report has passed the input register and the result
// register, with the decode as a single pass of logic between them. The trigger
// state updates as an item leaves the input register, so back-to-back items see
// each other's effects in order. Configuration writes are always accepted and
// should be made while no item is in flight.
module gamepad_report_axis_decoder_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  gpad_pkg::in_item_t   in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output gpad_pkg::out_item_t  out_item,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  gpad_pkg::cfg_index_t cfg_index,
  input  logic [15:0]          cfg_data
);
  import gpad_pkg::*;

  // input register
  logic        s1_valid_r, s1_valid_nxt;
  in_item_t    s1_item_r;
  // result register
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_item_r;
  // registers and trigger state
  cfg_t        cfg_r, cfg_nxt;
  trig_state_t state_r, state_nxt;
  out_item_t   result;

  logic s1_advance;
  logic in_take;
  logic load_result;

  // the input register moves on whenever the result register is free or draining
  assign s1_advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready    = !s1_valid_r || s1_advance;
  assign in_take     = in_valid && in_ready;
  // ticks leave the input register without a result
  assign load_result = s1_advance && (s1_item_r.mode == MODE_REPORT);

  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  gpad_update u_update (
    .item      (s1_item_r),
    .cfg       (cfg_r),
    .state     (state_r),
    .state_nxt (state_nxt),
    .result    (result)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_ready) begin
      s1_valid_nxt = in_valid;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (load_result) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_SIDE_THRESHOLD:   cfg_nxt.side_threshold   = cfg_data[6:0];
        CFG_STABLE_NOISE:     cfg_nxt.stable_noise     = cfg_data[7:0];
        CFG_RELEASE_MOVEMENT: cfg_nxt.release_movement = cfg_data[7:0];
        CFG_ARM_DELAY_TICKS:  cfg_nxt.arm_delay_ticks  = cfg_data;
        default:              cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      cfg_r       <= CFG_RESET;
      state_r     <= STATE_RESET;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      cfg_r       <= cfg_nxt;
      if (s1_advance) begin
        state_r <= state_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r <= in_item;
    end
    if (load_result) begin
      out_item_r <= result;
    end
  end

endmodule

@@ dv/gpad_axes_checker.sv @@
// scoreboard for the gamepad report axis decoder: predicts result items and compares them
module gpad_axes_checker
  import gpad_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  in_item_t    in_item,
  input  logic        out_valid,
  input  logic        out_ready,
  input  out_item_t   out_item,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  cfg_index_t  cfg_index,
  input  logic [15:0] cfg_data,
  output int          fail_count,
  output int          pending
);

  localparam int CENTER          = 128;
  localparam int SHORTEST_REPORT = 11;
  localparam int FULL_SCALE      = 32767;

  // register copies
  logic [6:0]  thr_reg;
  logic [7:0]  noise_reg;
  logic [7:0]  move_reg;
  logic [15:0] delay_reg;

  // trigger tracking state
  logic        active;
  side_t       first_side;
  logic        held;
  logic        armed;
  logic [7:0]  last_trig;
  logic [15:0] stable_ticks;

  out_item_t expected_axes[$];

  function automatic void drop_trigger_state();
    active       = 1'b0;
    first_side   = SIDE_NONE;
    held         = 1'b0;
    armed        = 1'b0;
    last_trig    = 8'd128;
    stable_ticks = 16'd0;
  endfunction

  function automatic logic signed [15:0] stick_value(logic [7:0] raw);
    int v;
    v = (int'(raw) - CENTER) * 256;
    return v[15:0];
  endfunction

  // decodes one report and, if it is long enough, advances the trigger state
  function automatic out_item_t decode_report(in_item_t it);
    out_item_t  r;
    logic [7:0] c;
    logic [7:0] move;
    side_t      side;
    int         mag;
    r = '0;
    if (int'(it.report_length) < SHORTEST_REPORT) return r;
    r.axes_valid = 1'b1;
    r.left_x     = stick_value(it.left_x_raw);
    r.left_y     = stick_value(it.left_y_raw);
    r.right_x    = stick_value(it.right_x_raw);
    r.right_y    = stick_value(it.right_y_raw);
    c = it.combined_trigger;
    if (int'(c) + int'(thr_reg) < CENTER) side = SIDE_LEFT;
    else if (int'(c) > CENTER + int'(thr_reg)) side = SIDE_RIGHT;
    else side = SIDE_NONE;

    if (!it.status_byte[7]) begin
      drop_trigger_state();
    end else if (!active) begin
      active       = 1'b1;
      first_side   = side;
      last_trig    = c;
      stable_ticks = 16'd0;
    end else if (!held) begin
      if (first_side == SIDE_NONE && side != SIDE_NONE) begin
        first_side = side;
      end else if (side != SIDE_NONE && first_side != SIDE_NONE && side != first_side) begin
        held         = 1'b1;
        armed        = 1'b0;
        stable_ticks = 16'd0;
      end
      last_trig = c;
    end else begin
      move = (c > last_trig) ? c - last_trig : last_trig - c;
      if (!armed) begin
        if (move <= noise_reg) begin
          if (stable_ticks >= delay_reg) armed = 1'b1;
        end else begin
          stable_ticks = 16'd0;
        end
      end else if (move >= move_reg) begin
        held         = 1'b0;
        first_side   = side;
        armed        = 1'b0;
        stable_ticks = 16'd0;
      end
      last_trig = c;
    end

    if (held) begin
      r.left_trigger   = 15'(FULL_SCALE);
      r.right_trigger  = 15'(FULL_SCALE);
      r.both_held_flag = 1'b1;
      return r;
    end
    if (int'(c) < CENTER) begin
      mag = (CENTER - int'(c)) * FULL_SCALE / CENTER;
      r.left_trigger = 15'((mag > FULL_SCALE) ? FULL_SCALE : mag);
    end
    if (int'(c) > CENTER) begin
      mag = (int'(c) - CENTER) * FULL_SCALE / 127;
      r.right_trigger = 15'((mag > FULL_SCALE) ? FULL_SCALE : mag);
    end
    return r;
  endfunction

  function automatic void check_field(string name, logic signed [31:0] want,
                                      logic signed [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin : watch
    out_item_t want;
    if (!rst_n) begin
      thr_reg    = 7'd10;
      noise_reg  = 8'd2;
      move_reg   = 8'd12;
      delay_reg  = 16'd80;
      fail_count = 0;
      drop_trigger_state();
      expected_axes.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SIDE_THRESHOLD:   thr_reg   = cfg_data[6:0];
          CFG_STABLE_NOISE:     noise_reg = cfg_data[7:0];
          CFG_RELEASE_MOVEMENT: move_reg  = cfg_data[7:0];
          CFG_ARM_DELAY_TICKS:  delay_reg = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (in_item.mode == MODE_TICK) begin
          if (stable_ticks != 16'hFFFF) stable_ticks++;
        end else begin
          expected_axes.insert(expected_axes.size(), decode_report(in_item));
        end
      end
      if (out_valid && out_ready) begin
        if (expected_axes.size() == 0) begin
          $error("result item with nothing expected");
          fail_count++;
        end else begin
          want = expected_axes.pop_front();
          check_field("axes_valid", 32'(want.axes_valid), 32'(out_item.axes_valid));
          check_field("left_x", 32'(want.left_x), 32'(out_item.left_x));
          check_field("left_y", 32'(want.left_y), 32'(out_item.left_y));
          check_field("right_x", 32'(want.right_x), 32'(out_item.right_x));
          check_field("right_y", 32'(want.right_y), 32'(out_item.right_y));
          check_field("left_trigger", 32'(want.left_trigger),
                      32'(out_item.left_trigger));
          check_field("right_trigger", 32'(want.right_trigger),
                      32'(out_item.right_trigger));
          check_field("both_held_flag", 32'(want.both_held_flag),
                      32'(out_item.both_held_flag));
        end
      end
    end
    pending <= expected_axes.size();
  end

endmodule

@@ dv/testbench.sv @@
// stimulus and verdict for the gamepad report axis decoder
module testbench;
  import gpad_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_item;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_item;
  logic        cfg_valid;
  logic        cfg_ready;
  cfg_index_t  cfg_index;
  logic [15:0] cfg_data;

  int          fail_count;
  int          pending;
  int unsigned cycle_count;
  int unsigned sent_items;
  int unsigned phase_end;
  bit          steady;       // when set, neither side idles

  // register settings as last written, only used to shape the stimulus
  int unsigned side_thr;
  int unsigned noise_band;
  int unsigned release_move;
  int unsigned arm_delay;
  int unsigned trig_now;     // last trigger byte sent with the flag held

  gamepad_report_axis_decoder_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  gpad_axes_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_item   (out_item),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog: a hung handshake ends the run here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // result side: a random stall before each item, none while steady
  initial begin : result_sink
    int stall;
    out_ready = 1'b0;
    @(posedge clk);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  // valid is only dropped when a gap is drawn, so back-to-back items keep it high
  task automatic send_item(input in_item_t it);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
    sent_items++;
  endtask

  // stop feeding, let every expected result come out, then cover the pipeline
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic put_reg(input cfg_index_t idx, input logic [15:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // writes all four registers back to back; unused upper data bits are random
  task automatic write_regs(input int unsigned thr, input int unsigned noise,
                            input int unsigned move, input int unsigned delay);
    logic [15:0] junk;
    junk         = 16'($urandom);
    side_thr     = thr;
    noise_band   = noise;
    release_move = move;
    arm_delay    = delay;
    cfg_valid <= 1'b1;
    put_reg(CFG_SIDE_THRESHOLD, {junk[8:0], thr[6:0]});
    put_reg(CFG_STABLE_NOISE, {junk[15:8], noise[7:0]});
    put_reg(CFG_RELEASE_MOVEMENT, {junk[7:0], move[7:0]});
    put_reg(CFG_ARM_DELAY_TICKS, delay[15:0]);
    cfg_valid <= 1'b0;
  endtask

  function automatic in_item_t fixed_report(logic [7:0] len, logic [7:0] lx, logic [7:0] ly,
                                            logic [7:0] rx, logic [7:0] ry,
                                            logic [7:0] status, logic [7:0] trig);
    in_item_t it;
    it.mode             = MODE_REPORT;
    it.report_length    = len;
    it.left_x_raw       = lx;
    it.left_y_raw       = ly;
    it.right_x_raw      = rx;
    it.right_y_raw      = ry;
    it.status_byte      = status;
    it.combined_trigger = trig;
    return it;
  endfunction

  // well-formed report with random sticks
  function automatic in_item_t report_item(logic [7:0] status, logic [7:0] trig);
    return fixed_report(8'($urandom_range(11, 255)), 8'($urandom), 8'($urandom),
                        8'($urandom), 8'($urandom), status, trig);
  endfunction

  // tick items carry random junk in the report fields
  function automatic in_item_t tick_item();
    in_item_t it;
    it      = report_item(8'($urandom), 8'($urandom));
    it.mode = MODE_TICK;
    if ($urandom_range(0, 3) == 0) it.report_length = 8'($urandom_range(0, 10));
    return it;
  endfunction

  // trigger byte that lands on the given side under the current threshold
  function automatic logic [7:0] pick_trig(side_t s);
    int unsigned lo;
    int unsigned hi;
    logic [7:0]  c;
    case (s)
      SIDE_LEFT: begin
        c = 8'($urandom_range(0, 127 - side_thr));
      end
      SIDE_RIGHT: begin
        // a wide threshold leaves no right side at all
        if (side_thr >= 127) c = 8'd128;
        else c = 8'($urandom_range(129 + side_thr, 255));
      end
      default: begin
        lo = (side_thr > 128) ? 0 : 128 - side_thr;
        hi = (128 + side_thr > 255) ? 255 : 128 + side_thr;
        c  = 8'($urandom_range(lo, hi));
      end
    endcase
    return c;
  endfunction

  // small move from the last value, inside the noise band
  function automatic logic [7:0] near_trig();
    int unsigned d;
    d = $urandom_range(0, noise_band);
    if ($urandom_range(0, 1) != 0 && trig_now + d <= 255) return 8'(trig_now + d);
    if (trig_now >= d) return 8'(trig_now - d);
    return 8'(trig_now);
  endfunction

  // report with the digital trigger flag held
  task automatic press(input logic [7:0] c);
    logic [7:0] status;
    status    = 8'($urandom);
    status[7] = 1'b1;
    trig_now  = 32'(c);
    send_item(report_item(status, c));
  endtask

  // one side, then the other (both held), stable stretches with ticks, a release move,
  // and usually the flag dropped at the end
  task automatic trigger_gesture();
    side_t       first;
    side_t       other;
    int unsigned cap;
    int unsigned mv;
    logic [7:0]  c;
    logic [7:0]  status;
    first = ($urandom_range(0, 1) != 0) ? SIDE_LEFT : SIDE_RIGHT;
    other = (first == SIDE_LEFT) ? SIDE_RIGHT : SIDE_LEFT;
    cap   = (arm_delay + 2 > 100) ? 100 : arm_delay + 2;
    if ($urandom_range(0, 3) == 0) press(pick_trig(SIDE_NONE));
    repeat ($urandom_range(1, 3)) press(pick_trig(first));
    press(pick_trig(other));
    repeat ($urandom_range(1, 4)) begin
      repeat ($urandom_range(0, cap)) send_item(tick_item());
      // now and then a jump that restarts the stability count
      if ($urandom_range(0, 6) == 0) press(8'($urandom));
      else press(near_trig());
    end
    mv = release_move + $urandom_range(0, 20);
    if (trig_now + mv <= 255) c = 8'(trig_now + mv);
    else if (trig_now >= mv) c = 8'(trig_now - mv);
    else c = (trig_now < 128) ? 8'd255 : 8'd0;
    press(c);
    repeat ($urandom_range(0, 2)) press(8'($urandom));
    if ($urandom_range(0, 3) != 0) begin
      status    = 8'($urandom);
      status[7] = 1'b0;
      send_item(report_item(status, 8'($urandom)));
    end
  endtask

  // fully random item, often short
  task automatic noise_item();
    logic [63:0] w;
    in_item_t    it;
    w  = {$urandom, $urandom};
    it = w[56:0];
    if ($urandom_range(0, 4) == 0) it.report_length = 8'($urandom_range(0, 10));
    send_item(it);
  endtask

  initial begin : stimulus
    int unsigned pick;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_item     = '0;
    cfg_valid   = 1'b0;
    cfg_index   = CFG_SIDE_THRESHOLD;
    cfg_data    = '0;
    steady      = 1'b0;
    cycle_count = 0;
    sent_items  = 0;
    side_thr     = 10;
    noise_band   = 2;
    release_move = 12;
    arm_delay    = 80;
    trig_now     = 128;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed items on the reset settings
    send_item(tick_item());
    // short reports: all-zero result, state left alone
    send_item(fixed_report(8'd0, 8'h12, 8'h34, 8'h56, 8'h78, 8'hFF, 8'd0));
    send_item(fixed_report(8'd10, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'h80, 8'd255));
    // stick and trigger extremes with the flag clear
    send_item(fixed_report(8'd11, 8'h00, 8'hFF, 8'h80, 8'h7F, 8'h00, 8'd0));
    send_item(fixed_report(8'd255, 8'hFF, 8'h00, 8'h7F, 8'h80, 8'h7F, 8'd255));
    // flag set at center, then left, then right: both held
    send_item(fixed_report(8'd11, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'd128));
    send_item(fixed_report(8'd200, 8'h01, 8'hFE, 8'h40, 8'hC0, 8'h80, 8'd117));
    send_item(fixed_report(8'd64, 8'h55, 8'hAA, 8'h33, 8'hCC, 8'h80, 8'd139));
    repeat (3) send_item(tick_item());
    // stable but not long enough to arm, then a move that restarts the count
    send_item(fixed_report(8'd12, 8'h0F, 8'hF0, 8'h3C, 8'hC3, 8'h81, 8'd140));
    send_item(fixed_report(8'd12, 8'h0F, 8'hF0, 8'h3C, 8'hC3, 8'h81, 8'd150));
    // flag dropped clears everything
    send_item(fixed_report(8'd30, 8'h80, 8'h80, 8'h80, 8'h80, 8'h7F, 8'd150));
    // just inside the threshold on both sides: no side yet
    send_item(fixed_report(8'd30, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'd118));
    send_item(fixed_report(8'd30, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'd138));
    send_item(fixed_report(8'd30, 8'h80, 8'h80, 8'h80, 8'h80, 8'hC0, 8'd0));
    send_item(fixed_report(8'd30, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'd255));
    trig_now = 255;

    // random phases, each on its own register setting
    for (int p = 0; p < 8; p++) begin
      wait_idle();
      case (p)
        0: write_regs(0, 0, 0, 0);              // zero arm delay, any move releases
        1: write_regs(127, 255, 255, 65535);     // widest threshold, no right side
        2: write_regs(20, 255, 255, 65535);
        3: write_regs(10, 2, 12, 80);
        7: write_regs($urandom_range(0, 127), $urandom_range(0, 255),
                      $urandom_range(0, 255), $urandom_range(0, 40));
        default: write_regs($urandom_range(0, 60), $urandom_range(0, 10),
                            $urandom_range(0, 80), $urandom_range(0, 20));
      endcase
      steady    = (p == 5);
      phase_end = sent_items + ((p == 3) ? 200 : (p == 1 || p == 2) ? 60 : 120);
      while (sent_items < phase_end) begin
        pick = $urandom_range(0, 99);
        if (pick < 65) trigger_gesture();
        else if (pick < 80) repeat ($urandom_range(1, 8)) send_item(tick_item());
        else noise_item();
      end
      steady = 1'b0;
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
